>>> hdl/qte_pkg.sv
`timescale 1ns / 1ps

package qte_pkg;

    // CORDIC depth and output angle resolution
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 6;

    // internal angle unit is 2^-ZFRAC degree
    localparam int ZFRAC      = 20;
    localparam int OUT_SHIFT  = ZFRAC - ANGLE_FRAC_BITS;
    localparam int QF         = 28;                 // matrix terms are Q28
    localparam int MW         = 36;                 // matrix term width
    localparam int AW         = QF + 2;             // saturated asin argument
    localparam int RW         = 2 * QF + 2;         // radicand / remainder
    localparam int SQRT_STEPS = QF + 1;             // one root bit per cell
    localparam int SW         = 5;                  // step index width
    localparam int XW         = 38;                 // CORDIC x/y width
    localparam int ZW         = 32;                 // CORDIC angle width

    localparam logic signed [MW-1:0] ONE_M   = MW'(64'sd1 <<< QF);
    localparam logic signed [AW-1:0] ONE_A   = AW'(64'sd1 <<< QF);
    localparam logic [RW-1:0]        RAD_ONE = RW'(1) << (2 * QF);

    localparam logic signed [ZW-1:0] DEG90  = ZW'(64'sd90 <<< ZFRAC);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(64'sd180 <<< ZFRAC);
    localparam logic signed [ZW-1:0] HALF_LSB = ZW'(64'sd1 <<< (OUT_SHIFT - 1));

    localparam logic signed [ZW-1:0] ROLL_HI  = ZW'(64'sd360 <<< ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] PITCH_HI = ZW'(64'sd90 <<< ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] YAW_HI   = ZW'(64'sd180 <<< ANGLE_FRAC_BITS);

    // rotation-matrix terms and saturated asin argument
    typedef struct packed {
        logic signed [MW-1:0] m11;
        logic signed [MW-1:0] m12;
        logic signed [MW-1:0] m23;
        logic signed [MW-1:0] m33;
        logic signed [AW-1:0] a;
        logic                 clamped;
    } t_terms;

    // square-root cell payload
    typedef struct packed {
        t_terms          terms;
        logic [RW-1:0]   rem;
        logic [RW-1:0]   res;
    } t_root;

    // one CORDIC vector; fixed means z already holds the exact answer
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 fixed;
    } t_vec;

    typedef struct packed {
        t_vec roll;
        t_vec pitch;
        t_vec yaw;
        logic clamped;
    } t_rot;

    // atan(2^-i) in degrees, scaled by 2^20
    function automatic logic signed [ZW-1:0] atan_entry(input logic [SW-1:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd47185920;
            5'd1:    v = 32'sd27855475;
            5'd2:    v = 32'sd14718068;
            5'd3:    v = 32'sd7471121;
            5'd4:    v = 32'sd3750058;
            5'd5:    v = 32'sd1876857;
            5'd6:    v = 32'sd938658;
            5'd7:    v = 32'sd469357;
            5'd8:    v = 32'sd234682;
            5'd9:    v = 32'sd117342;
            5'd10:   v = 32'sd58671;
            5'd11:   v = 32'sd29335;
            5'd12:   v = 32'sd14668;
            5'd13:   v = 32'sd7334;
            5'd14:   v = 32'sd3667;
            5'd15:   v = 32'sd1833;
            5'd16:   v = 32'sd917;
            5'd17:   v = 32'sd458;
            5'd18:   v = 32'sd229;
            5'd19:   v = 32'sd115;
            5'd20:   v = 32'sd57;
            5'd21:   v = 32'sd29;
            5'd22:   v = 32'sd14;
            5'd23:   v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/qte_front.sv
`timescale 1ns / 1ps

module qte_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [15:0]     i_w,
    input  logic signed [15:0]     i_x,
    input  logic signed [15:0]     i_y,
    input  logic signed [15:0]     i_z,
    output logic                   o_valid,
    input  logic                   i_ready,
    output qte_pkg::t_root         o_data
);

    typedef struct packed {
        logic signed [31:0] ww;
        logic signed [31:0] xx;
        logic signed [31:0] zz;
        logic signed [31:0] xy;
        logic signed [31:0] wz;
        logic signed [31:0] xz;
        logic signed [31:0] wy;
        logic signed [31:0] yz;
        logic signed [31:0] wx;
    } t_prod;

    logic [3:0]      r_valid;
    logic [3:0]      rdy;
    t_prod           r_prod;
    qte_pkg::t_terms r_terms;
    qte_pkg::t_root  r_sq;
    qte_pkg::t_root  r_rad;

    t_prod                           n_prod;
    qte_pkg::t_terms                 n_terms;
    qte_pkg::t_root                  n_sq;
    qte_pkg::t_root                  n_rad;
    logic signed [qte_pkg::MW-1:0]   a_raw;
    logic [qte_pkg::AW-2:0]          a_mag;

    // stall chain: a stage moves when empty or when the next one moves
    assign rdy[3]  = !r_valid[3] || i_ready;
    assign rdy[2]  = !r_valid[2] || rdy[3];
    assign rdy[1]  = !r_valid[1] || rdy[2];
    assign rdy[0]  = !r_valid[0] || rdy[1];
    assign o_ready = rdy[0];
    assign o_valid = r_valid[3];
    assign o_data  = r_rad;

    // stage 1: component products
    always_comb begin
        n_prod.ww = 32'(i_w * i_w);
        n_prod.xx = 32'(i_x * i_x);
        n_prod.zz = 32'(i_z * i_z);
        n_prod.xy = 32'(i_x * i_y);
        n_prod.wz = 32'(i_w * i_z);
        n_prod.xz = 32'(i_x * i_z);
        n_prod.wy = 32'(i_w * i_y);
        n_prod.yz = 32'(i_y * i_z);
        n_prod.wx = 32'(i_w * i_x);
    end

    // stage 2: matrix terms, saturate the asin argument
    always_comb begin
        n_terms.m11 = ((qte_pkg::MW'(r_prod.ww) + qte_pkg::MW'(r_prod.xx)) <<< 1)
                      - qte_pkg::ONE_M;
        n_terms.m33 = ((qte_pkg::MW'(r_prod.ww) + qte_pkg::MW'(r_prod.zz)) <<< 1)
                      - qte_pkg::ONE_M;
        n_terms.m12 = (qte_pkg::MW'(r_prod.xy) + qte_pkg::MW'(r_prod.wz)) <<< 1;
        n_terms.m23 = (qte_pkg::MW'(r_prod.yz) + qte_pkg::MW'(r_prod.wx)) <<< 1;
        a_raw       = (qte_pkg::MW'(r_prod.wy) - qte_pkg::MW'(r_prod.xz)) <<< 1;
        priority if (a_raw > qte_pkg::ONE_M) begin
            n_terms.a       = qte_pkg::ONE_A;
            n_terms.clamped = 1'b1;
        end else if (a_raw < -qte_pkg::ONE_M) begin
            n_terms.a       = -qte_pkg::ONE_A;
            n_terms.clamped = 1'b1;
        end else begin
            n_terms.a       = qte_pkg::AW'(a_raw);
            n_terms.clamped = 1'b0;
        end
    end

    // stage 3: square of the argument
    always_comb begin
        a_mag      = r_terms.a[qte_pkg::AW-1] ? (qte_pkg::AW-1)'(-r_terms.a)
                                              : r_terms.a[qte_pkg::AW-2:0];
        n_sq.terms = r_terms;
        n_sq.rem   = qte_pkg::RW'(a_mag) * qte_pkg::RW'(a_mag);
        n_sq.res   = '0;
    end

    // stage 4: radicand 1 - a*a
    always_comb begin
        n_rad     = r_sq;
        n_rad.rem = qte_pkg::RAD_ONE - r_sq.rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (rdy[0]) r_valid[0] <= i_valid;
            if (rdy[1]) r_valid[1] <= r_valid[0];
            if (rdy[2]) r_valid[2] <= r_valid[1];
            if (rdy[3]) r_valid[3] <= r_valid[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid)    r_prod  <= n_prod;
        if (rdy[1] && r_valid[0]) r_terms <= n_terms;
        if (rdy[2] && r_valid[1]) r_sq    <= n_sq;
        if (rdy[3] && r_valid[2]) r_rad   <= n_rad;
    end

endmodule

>>> hdl/qte_sqrt_cell.sv
`timescale 1ns / 1ps

module qte_sqrt_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [qte_pkg::SW-1:0] i_step,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  qte_pkg::t_root         i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output qte_pkg::t_root         o_data
);

    logic                  r_valid;
    qte_pkg::t_root        r_data;
    qte_pkg::t_root        n_data;
    logic [qte_pkg::RW-1:0] bit_w;
    logic [qte_pkg::RW-1:0] trial;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // one root bit: subtract the trial value when it fits
    always_comb begin
        bit_w  = qte_pkg::RW'(1) << {i_step, 1'b0};
        trial  = i_data.res + bit_w;
        n_data = i_data;
        if (i_data.rem >= trial) begin
            n_data.rem = i_data.rem - trial;
            n_data.res = (i_data.res >> 1) + bit_w;
        end else begin
            n_data.res = i_data.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_data <= n_data;
    end

endmodule

>>> hdl/qte_prep.sv
`timescale 1ns / 1ps

module qte_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qte_pkg::t_root i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output qte_pkg::t_rot  o_data
);

    logic                          r_valid;
    qte_pkg::t_rot                 r_data;
    qte_pkg::t_rot                 n_data;
    logic signed [qte_pkg::XW-1:0] cos_x;

    // axis cases are exact; left half-plane is folded by +/-180
    function automatic qte_pkg::t_vec vec_init(input logic signed [qte_pkg::XW-1:0] y,
                                               input logic signed [qte_pkg::XW-1:0] x);
        qte_pkg::t_vec v;
        v.x     = x;
        v.y     = y;
        v.z     = '0;
        v.fixed = 1'b0;
        priority if (y == 0) begin
            v.fixed = 1'b1;
            v.z     = (x < 0) ? qte_pkg::DEG180 : '0;
        end else if (x == 0) begin
            v.fixed = 1'b1;
            v.z     = (y > 0) ? qte_pkg::DEG90 : -qte_pkg::DEG90;
        end else if (x < 0) begin
            v.z = (y > 0) ? qte_pkg::DEG180 : -qte_pkg::DEG180;
            v.x = -x;
            v.y = -y;
        end else begin
            // right half-plane goes to the rotations as it is
            v.fixed = 1'b0;
        end
        return v;
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        cos_x          = signed'(i_data.res[qte_pkg::XW-1:0]);
        n_data.roll    = vec_init(qte_pkg::XW'(i_data.terms.m23), qte_pkg::XW'(i_data.terms.m33));
        n_data.pitch   = vec_init(qte_pkg::XW'(i_data.terms.a), cos_x);
        n_data.yaw     = vec_init(qte_pkg::XW'(i_data.terms.m12), qte_pkg::XW'(i_data.terms.m11));
        n_data.clamped = i_data.terms.clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_data <= n_data;
    end

endmodule

>>> hdl/qte_cordic_cell.sv
`timescale 1ns / 1ps

module qte_cordic_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [qte_pkg::SW-1:0] i_step,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  qte_pkg::t_rot          i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output qte_pkg::t_rot          o_data
);

    logic                  r_valid;
    qte_pkg::t_rot         r_data;
    qte_pkg::t_rot         n_data;
    logic signed [qte_pkg::ZW-1:0] ang;

    // one vectoring micro-rotation, drives y toward zero
    function automatic qte_pkg::t_vec rotate(input qte_pkg::t_vec v,
                                             input logic [qte_pkg::SW-1:0] s,
                                             input logic signed [qte_pkg::ZW-1:0] t);
        qte_pkg::t_vec r;
        logic signed [qte_pkg::XW-1:0] dx;
        logic signed [qte_pkg::XW-1:0] dy;
        r  = v;
        dx = v.y >>> s;
        dy = v.x >>> s;
        if (!v.fixed) begin
            if (v.y > 0) begin
                r.x = v.x + dx;
                r.y = v.y - dy;
                r.z = v.z + t;
            end else begin
                r.x = v.x - dx;
                r.y = v.y + dy;
                r.z = v.z - t;
            end
        end
        return r;
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        ang            = qte_pkg::atan_entry(i_step);
        n_data.roll    = rotate(i_data.roll, i_step, ang);
        n_data.pitch   = rotate(i_data.pitch, i_step, ang);
        n_data.yaw     = rotate(i_data.yaw, i_step, ang);
        n_data.clamped = i_data.clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_data <= n_data;
    end

endmodule

>>> hdl/quaternion_to_euler_angles_core.sv
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// input    | i_in_valid / o_in_ready    | i_quat_w, i_quat_x, i_quat_y, i_quat_z
// output   | o_out_valid / i_out_ready  | o_roll_angle, o_pitch_angle, o_yaw_angle,
//          |                            | o_pitch_clamped
//
// One beat per cycle in and out while the output is not stalled; the pipeline is 4 front stages
// (products, matrix terms, square, radicand), 29 square-root cells, one
// CORDIC setup stage, CORDIC_STAGES rotation cells and the output register.
// Every stage holds its beat under back-pressure and fills its bubbles, so
// the input keeps taking beats while a result waits until the pipeline is
// full. Reset clears valid bits.

module quaternion_to_euler_angles_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [14:0]        o_roll_angle,
    output logic signed [13:0] o_pitch_angle,
    output logic signed [14:0] o_yaw_angle,
    output logic               o_pitch_clamped
);

    localparam int NS = qte_pkg::SQRT_STEPS;
    localparam int NC = qte_pkg::CORDIC_STAGES;

    logic           sq_valid [NS+1];
    logic           sq_ready [NS+1];
    qte_pkg::t_root sq_data  [NS+1];
    logic           cr_valid [NC+1];
    logic           cr_ready [NC+1];
    qte_pkg::t_rot  cr_data  [NC+1];

    logic                          r_valid;
    logic [14:0]                   r_roll;
    logic signed [13:0]            r_pitch;
    logic signed [14:0]            r_yaw;
    logic                          r_clamped;
    logic                          out_rdy;
    logic signed [qte_pkg::ZW-1:0] roll_q;
    logic signed [qte_pkg::ZW-1:0] pitch_q;
    logic signed [qte_pkg::ZW-1:0] yaw_q;

    // round half up to the output unit, then clamp
    function automatic logic signed [qte_pkg::ZW-1:0] to_out(
        input logic signed [qte_pkg::ZW-1:0] z,
        input logic signed [qte_pkg::ZW-1:0] lo,
        input logic signed [qte_pkg::ZW-1:0] hi);
        logic signed [qte_pkg::ZW-1:0] r;
        r = (z + qte_pkg::HALF_LSB) >>> qte_pkg::OUT_SHIFT;
        priority if (r < lo) begin
            r = lo;
        end else if (r > hi) begin
            r = hi;
        end else begin
            // in range, keep as is
            r = r;
        end
        return r;
    endfunction

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_valid (sq_valid[0]),
        .i_ready (sq_ready[0]),
        .o_data  (sq_data[0])
    );

    // square-root chain, most significant root bit first
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (qte_pkg::SW'(NS - 1 - k)),
            .i_valid (sq_valid[k]),
            .o_ready (sq_ready[k]),
            .i_data  (sq_data[k]),
            .o_valid (sq_valid[k+1]),
            .i_ready (sq_ready[k+1]),
            .o_data  (sq_data[k+1])
        );
    end

    qte_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid[NS]),
        .o_ready (sq_ready[NS]),
        .i_data  (sq_data[NS]),
        .o_valid (cr_valid[0]),
        .i_ready (cr_ready[0]),
        .o_data  (cr_data[0])
    );

    // CORDIC chain, three angles side by side
    for (genvar k = 0; k < NC; k++) begin : g_cordic
        qte_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (qte_pkg::SW'(k)),
            .i_valid (cr_valid[k]),
            .o_ready (cr_ready[k]),
            .i_data  (cr_data[k]),
            .o_valid (cr_valid[k+1]),
            .i_ready (cr_ready[k+1]),
            .o_data  (cr_data[k+1])
        );
    end

    // output register
    assign out_rdy      = !r_valid || i_out_ready;
    assign cr_ready[NC] = out_rdy;

    always_comb begin
        roll_q  = to_out(cr_data[NC].roll.z + qte_pkg::DEG180, '0, qte_pkg::ROLL_HI);
        pitch_q = to_out(cr_data[NC].pitch.z, -qte_pkg::PITCH_HI, qte_pkg::PITCH_HI);
        yaw_q   = to_out(cr_data[NC].yaw.z, -qte_pkg::YAW_HI, qte_pkg::YAW_HI);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_rdy) begin
            r_valid <= cr_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && cr_valid[NC]) begin
            r_roll    <= roll_q[14:0];
            r_pitch   <= pitch_q[13:0];
            r_yaw     <= yaw_q[14:0];
            r_clamped <= cr_data[NC].clamped;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_roll_angle    = r_roll;
    assign o_pitch_angle   = r_pitch;
    assign o_yaw_angle     = r_yaw;
    assign o_pitch_clamped = r_clamped;

endmodule
